// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/srtf_pkg.sv =====
// Shared widths, record types and controller states of the SRTF scheduler.
package srtf_pkg;

  localparam int MAX_PROCS_DEF = 16;
  localparam int ID_W          = 8;
  localparam int ARR_W         = 16;
  localparam int BURST_W       = 12;
  localparam int TIME_W        = 18;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
  } stat_t;

  typedef struct packed {
    logic [BURST_W-1:0] remaining;
    logic [TIME_W-1:0]  completion;
  } dyn_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_TICK,
    S_SCAN,
    S_DRAIN,
    S_UPDATE,
    S_OUT_RD,
    S_OUT_TA,
    S_OUT_W,
    S_OUT_SEND
  } state_t;

endpackage

// ===== rtl/srtf_if.sv =====
// Job and result channel interfaces of the SRTF scheduler.
interface srtf_in_if import srtf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    process_id;
  logic [ARR_W-1:0]   arrival_time;
  logic [BURST_W-1:0] burst_time;
  logic               last_process;

  modport source (output valid, output process_id, output arrival_time,
                  output burst_time, output last_process, input ready);
  modport sink (input valid, input process_id, input arrival_time,
                input burst_time, input last_process, output ready);
endinterface

interface srtf_out_if import srtf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   result_id;
  logic [TIME_W-1:0] completion_time;
  logic [TIME_W-1:0] turnaround_time;
  logic [TIME_W-1:0] waiting_time;
  logic              last_result;

  modport source (output valid, output result_id, output completion_time,
                  output turnaround_time, output waiting_time, output last_result,
                  input ready);
  modport sink (input valid, input result_id, input completion_time,
                input turnaround_time, input waiting_time, input last_result,
                output ready);
endinterface

// ===== rtl/srtf_preemptive_scheduler_core.sv =====
// Preemptive shortest-remaining-time-first scheduler core.
// Usage:
//   jobs    : one process record per transaction (id, arrival, burst, last flag).
//             Records load one per cycle; last_process, or the MAX_PROCS-th
//             record, closes the job set.
//   results : one transaction per loaded process, in load order, last_result
//             set on the final one.
// Operation: after the closing record the core simulates tick by tick. A tick
//   is S_TICK, a scan of the n entries through the one read port of the
//   record memories, S_DRAIN, then a write back in S_UPDATE; a gap with nothing
//   ready costs one scan and jumps to the next arrival. A result takes S_OUT_RD,
//   S_OUT_TA, S_OUT_W, S_OUT_SEND and any receiver stall. Throughput is one job
//   set at a time: jobs.ready is low from the closing record until the last result leaves.
// Reset: the job set is emptied and the core waits for records; the memories
//   are not cleared since every entry is written before it is read.
// Stall: a result is held in the output register until results.ready is high.
module srtf_preemptive_scheduler_core import srtf_pkg::*; #(
  parameter int MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  srtf_in_if.sink    jobs,
  srtf_out_if.source results
);

  `include "assert_macros.svh"

  localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int TICK_W = $clog2((1 << ARR_W) + MAX_PROCS * (1 << BURST_W)) + 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_PROCS - 1);

  state_t             state, state_next;
  logic [CNT_W-1:0]   loaded_count;
  logic [CNT_W-1:0]   done_count;
  logic [TICK_W-1:0]  tick;
  logic [ARR_W-1:0]   min_arr;
  logic [IDX_W-1:0]   scan_idx;
  logic               rd_vld;
  logic [IDX_W-1:0]   rd_idx;
  logic               found;
  logic [BURST_W-1:0] best;
  logic [IDX_W-1:0]   pick;
  logic               next_vld;
  logic [ARR_W-1:0]   next_arr;
  logic [IDX_W-1:0]   out_idx;
  logic [ID_W-1:0]    hold_id;
  logic [TIME_W-1:0]  hold_c;
  logic [TIME_W-1:0]  hold_ta;
  logic [BURST_W-1:0] hold_burst;
  logic               out_vld;
  logic [ID_W-1:0]    out_id;
  logic [TIME_W-1:0]  out_c;
  logic [TIME_W-1:0]  out_ta;
  logic [TIME_W-1:0]  out_w;
  logic               out_last;

  logic               job_acc, res_acc, close_set;
  logic [IDX_W-1:0]   slot, n_last;
  logic [ARR_W-1:0]   min_cur;
  logic               stat_we, dyn_we;
  logic [IDX_W-1:0]   dyn_waddr, raddr;
  stat_t              stat_wdata, stat_q;
  dyn_t               dyn_wdata, dyn_q;
  logic               take, later;
  logic [TIME_W-1:0]  arr_ext, burst_ext;

  assign job_acc   = jobs.valid && jobs.ready;
  assign res_acc   = results.valid && results.ready;
  assign slot      = IDX_W'(loaded_count);
  assign n_last    = IDX_W'(loaded_count - CNT_W'(1));
  assign close_set = jobs.last_process || (slot == LAST_SLOT);
  assign min_cur   = (loaded_count == '0 || jobs.arrival_time < min_arr) ?
                     jobs.arrival_time : min_arr;

  assign take  = rd_vld && (TICK_W'(stat_q.arrival) <= tick) &&
                 (dyn_q.remaining != '0) && (!found || dyn_q.remaining < best);
  assign later = rd_vld && (dyn_q.remaining != '0) &&
                 (TICK_W'(stat_q.arrival) > tick) &&
                 (!next_vld || stat_q.arrival < next_arr);

  assign arr_ext   = TIME_W'(stat_q.arrival);
  assign burst_ext = TIME_W'(hold_burst);

  srtf_ram #(.WIDTH($bits(stat_t)), .DEPTH(MAX_PROCS)) u_stat_ram (
    .clk   (clk),
    .we    (stat_we),
    .waddr (slot),
    .wdata (stat_wdata),
    .raddr (raddr),
    .rdata (stat_q)
  );

  srtf_ram #(.WIDTH($bits(dyn_t)), .DEPTH(MAX_PROCS)) u_dyn_ram (
    .clk   (clk),
    .we    (dyn_we),
    .waddr (dyn_waddr),
    .wdata (dyn_wdata),
    .raddr (raddr),
    .rdata (dyn_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (job_acc && close_set) state_next = S_TICK;
      end
      S_TICK: begin
        state_next = (done_count == loaded_count) ? S_OUT_RD : S_SCAN;
      end
      S_SCAN: begin
        if (scan_idx == n_last) state_next = S_DRAIN;
      end
      S_DRAIN:  state_next = S_UPDATE;
      S_UPDATE: begin
        state_next = (found || next_vld) ? S_TICK : S_OUT_RD;
      end
      S_OUT_RD: state_next = S_OUT_TA;
      S_OUT_TA: state_next = S_OUT_W;
      S_OUT_W:  state_next = S_OUT_SEND;
      S_OUT_SEND: begin
        if (res_acc) state_next = (out_idx == n_last) ? S_LOAD : S_OUT_RD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_comb begin
    jobs.ready           = (state == S_LOAD);
    stat_we              = job_acc;
    stat_wdata.id        = jobs.process_id;
    stat_wdata.arrival   = jobs.arrival_time;
    stat_wdata.burst     = jobs.burst_time;
    dyn_we               = job_acc || (state == S_UPDATE && found);
    dyn_waddr            = (state == S_LOAD) ? slot : pick;
    dyn_wdata.remaining  = jobs.burst_time;
    dyn_wdata.completion = TIME_W'(jobs.arrival_time);
    if (state != S_LOAD) begin
      dyn_wdata.remaining  = best - BURST_W'(1);
      dyn_wdata.completion = TIME_W'(tick + TICK_W'(1));
    end
    raddr = (state == S_OUT_RD) ? out_idx : scan_idx;
  end

  assign results.valid           = out_vld;
  assign results.result_id       = out_id;
  assign results.completion_time = out_c;
  assign results.turnaround_time = out_ta;
  assign results.waiting_time    = out_w;
  assign results.last_result     = out_last;

  always_ff @(posedge clk) begin
    rd_idx <= scan_idx;
    if (take) begin
      best <= dyn_q.remaining;
      pick <= rd_idx;
    end
    if (later) begin
      next_arr <= stat_q.arrival;
    end
    case (state)
      S_LOAD: begin
        if (job_acc) begin
          min_arr <= min_cur;
        end
      end
      S_OUT_TA: begin
        hold_id    <= stat_q.id;
        hold_c     <= dyn_q.completion;
        hold_ta    <= (dyn_q.completion >= arr_ext) ? dyn_q.completion - arr_ext : '0;
        hold_burst <= stat_q.burst;
      end
      S_OUT_W: begin
        out_id   <= hold_id;
        out_c    <= hold_c;
        out_ta   <= hold_ta;
        out_w    <= (hold_ta >= burst_ext) ? hold_ta - burst_ext : '0;
        out_last <= (out_idx == n_last);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      loaded_count <= '0;
      done_count   <= '0;
      tick         <= '0;
      scan_idx     <= '0;
      rd_vld       <= 1'b0;
      found        <= 1'b0;
      next_vld     <= 1'b0;
      out_idx      <= '0;
      out_vld      <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == S_SCAN);
      if (take) found <= 1'b1;
      if (later) next_vld <= 1'b1;
      case (state)
        S_LOAD: begin
          if (job_acc) begin
            loaded_count <= loaded_count + CNT_W'(1);
            done_count   <= ((loaded_count == '0) ? '0 : done_count) +
                            CNT_W'(jobs.burst_time == '0);
            if (close_set) tick <= TICK_W'(min_cur);
          end
        end
        S_TICK: begin
          scan_idx <= '0;
          found    <= 1'b0;
          next_vld <= 1'b0;
          out_idx  <= '0;
        end
        S_SCAN: begin
          scan_idx <= scan_idx + IDX_W'(1);
        end
        S_UPDATE: begin
          out_idx <= '0;
          if (found) begin
            tick <= tick + TICK_W'(1);
            if (best == BURST_W'(1)) done_count <= done_count + CNT_W'(1);
          end else if (next_vld) begin
            tick <= TICK_W'(next_arr);
          end
        end
        S_OUT_W: begin
          out_vld <= 1'b1;
        end
        S_OUT_SEND: begin
          if (res_acc) begin
            out_vld <= 1'b0;
            if (out_idx == n_last) begin
              loaded_count <= '0;
            end else begin
              out_idx <= out_idx + IDX_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  `ASSERT_IMP(a_ready_idle, jobs.ready, !results.valid)
  `ASSERT_IMP(a_count_range, 1'b1, loaded_count <= CNT_W'(MAX_PROCS))
  `ASSERT_IMP(a_done_range, state != S_LOAD, done_count <= loaded_count)
  `ASSERT_NXT(a_set_closed, res_acc && results.last_result, loaded_count == '0)
  `ASSERT_NXT(a_tick_step, state == S_UPDATE && found, tick == $past(tick) + 1'b1)

endmodule

// ===== rtl/srtf_ram.sv =====
// Generic simple dual-port RAM with registered read.
module srtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
